FILE: rtl/sch_pkg.sv
// ----------------------------------------------------------------------------
// sch_pkg
// shared types and constants of the skewed cuckoo hash table core
// ----------------------------------------------------------------------------
package sch_pkg;

    localparam int WORD_W            = 64;
    localparam int WAYS              = 4;
    localparam int WAY_SEL_W         = 2;
    localparam int KEY_PORT_W        = 32;
    localparam int VALUE_PORT_W      = 32;
    localparam int MAXD_W            = 8;
    localparam int KICK_W            = MAXD_W + 1;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int INDEX_WIDTH_DEF   = 10;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 8'd16;

    localparam logic OPCODE_GET = 1'b0;
    localparam logic OPCODE_SET = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FAIL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_EVAL
    } state_t;

    typedef struct packed {
        logic    load;
        logic    hash_step;
        logic    rd_en;
        logic    wr_match;
        logic    wr_empty;
        logic    kick;
        logic    res_load;
        status_t res_code;
        logic    clr_step;
    } cmd_t;

    typedef struct packed {
        logic op_set;
        logic found;
        logic any_empty;
        logic t_over;
        logic hash_last;
        logic clr_last;
    } stat_t;

endpackage

FILE: rtl/skewed_cuckoo_hash_table_core.sv
// ----------------------------------------------------------------------------
// skewed_cuckoo_hash_table_core
// four-way skewed cuckoo hash table with get and set requests
// ----------------------------------------------------------------------------
// After reset the core sweeps all four way memories to empty, one entry per
// cycle until every entry is cleared, and holds in_stall high meanwhile. Each
// request passes an accept step, a hash step per key chunk (F = KEY_WIDTH /
// INDEX_WIDTH chunks, at least 1, one chunk folded per cycle for all ways at
// once), a memory read step and an evaluate step. A set that has to displace
// runs the hash, read and evaluate steps again per kick, bounded by maxd_reg.
// A new request is taken while the previous response still waits on
// out_stall.
module skewed_cuckoo_hash_table_core #(
    parameter int KEY_WIDTH   = sch_pkg::KEY_WIDTH_DEF,
    parameter int INDEX_WIDTH = sch_pkg::INDEX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [sch_pkg::KEY_PORT_W-1:0]    lookup_key,
    input  logic [sch_pkg::VALUE_PORT_W-1:0]  new_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [sch_pkg::VALUE_PORT_W-1:0]  read_value,
    input  logic                              cfg_write_en,
    input  logic [sch_pkg::MAXD_W-1:0]        cfg_write_data
);

    sch_pkg::cmd_t  cmd;
    sch_pkg::stat_t stat;

    sch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    sch_datapath #(
        .KEY_WIDTH   (KEY_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .lookup_key     (lookup_key),
        .new_value      (new_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .status         (status),
        .read_value     (read_value)
    );

endmodule

FILE: rtl/sch_datapath.sv
// ----------------------------------------------------------------------------
// sch_datapath
// way memories, iterative skewed index hash, probe compare and result regs
// ----------------------------------------------------------------------------
module sch_datapath #(
    parameter int KEY_WIDTH   = sch_pkg::KEY_WIDTH_DEF,
    parameter int INDEX_WIDTH = sch_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sch_pkg::cmd_t                       cmd,
    output sch_pkg::stat_t                      stat,
    input  logic                                opcode,
    input  logic [sch_pkg::KEY_PORT_W-1:0]      lookup_key,
    input  logic [sch_pkg::VALUE_PORT_W-1:0]    new_value,
    input  logic                                cfg_write_en,
    input  logic [sch_pkg::MAXD_W-1:0]          cfg_write_data,
    output logic [1:0]                          status,
    output logic [sch_pkg::VALUE_PORT_W-1:0]    read_value
);

    localparam int DEPTH = 1 << INDEX_WIDTH;
    localparam int NF    = (KEY_WIDTH / INDEX_WIDTH > 0) ? KEY_WIDTH / INDEX_WIDTH : 1;
    localparam int CNT_W = $clog2(NF + 1);
    localparam int KPW   = (KEY_WIDTH > INDEX_WIDTH) ? KEY_WIDTH : INDEX_WIDTH;
    localparam int LAST  = (KEY_WIDTH >= INDEX_WIDTH) ? KEY_WIDTH - INDEX_WIDTH : 0;
    localparam int WW    = sch_pkg::WORD_W;

    function automatic logic [INDEX_WIDTH-1:0] mix_fwd(input logic [INDEX_WIDTH-1:0] x);
        mix_fwd = {x[0] ^ x[INDEX_WIDTH-1], x[INDEX_WIDTH-1:1]};
    endfunction

    function automatic logic [INDEX_WIDTH-1:0] mix_rev(input logic [INDEX_WIDTH-1:0] x);
        mix_rev = {x[INDEX_WIDTH-2:0], x[INDEX_WIDTH-1] ^ x[INDEX_WIDTH-2]};
    endfunction

    function automatic logic [INDEX_WIDTH-1:0] fold(input int w,
                                                    input logic [INDEX_WIDTH-1:0] acc,
                                                    input logic [INDEX_WIDTH-1:0] c);
        logic [INDEX_WIDTH-1:0] m;
        m = (w < 2) ? (mix_fwd(acc) ^ mix_rev(c)) : (mix_rev(acc) ^ mix_fwd(c));
        fold = m ^ (((w % 2) == 1) ? acc : c);
    endfunction

    logic [WW-1:0]               cur_word_reg, cur_word_next;
    logic                        op_reg;
    logic [KPW-1:0]              key_reg, key_next;
    logic [KPW-1:0]              chunk_reg, chunk_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [INDEX_WIDTH-1:0]      idx_reg [sch_pkg::WAYS];
    logic [INDEX_WIDTH-1:0]      clr_reg;
    logic [sch_pkg::KICK_W-1:0]  t_reg;
    logic [sch_pkg::MAXD_W-1:0]  maxd_reg;
    logic [1:0]                  status_reg;
    logic [sch_pkg::VALUE_PORT_W-1:0] value_reg;

    logic [WW-1:0]               rd_data [sch_pkg::WAYS];
    logic [sch_pkg::WAYS-1:0]    fnd, emp, we;
    logic [sch_pkg::WAY_SEL_W-1:0] match_w, empty_w, kick_w;
    logic [INDEX_WIDTH-1:0]      chunk;
    logic [KEY_WIDTH-1:0]        cur_key;
    logic [WW-1:0]               match_word;

    assign cur_key = cur_word_reg[KEY_WIDTH-1:0];
    assign kick_w  = t_reg[sch_pkg::WAY_SEL_W-1:0] + sch_pkg::WAY_SEL_W'(3);

    always_comb
    begin
        match_w = '0;
        empty_w = '0;
        for (int w = sch_pkg::WAYS - 1; w >= 0; w--)
        begin
            fnd[w] = (rd_data[w] != '0) && (rd_data[w][KEY_WIDTH-1:0] == cur_key);
            emp[w] = (rd_data[w] == '0);
            if (fnd[w])
                match_w = sch_pkg::WAY_SEL_W'(w);
            if (emp[w])
                empty_w = sch_pkg::WAY_SEL_W'(w);
        end
        match_word = rd_data[match_w];
    end

    always_comb
    begin
        for (int w = 0; w < sch_pkg::WAYS; w++)
        begin
            we[w] = cmd.clr_step
                 || (cmd.wr_match && match_w == sch_pkg::WAY_SEL_W'(w))
                 || (cmd.wr_empty && empty_w == sch_pkg::WAY_SEL_W'(w))
                 || (cmd.kick && kick_w == sch_pkg::WAY_SEL_W'(w));
        end
    end

    // next word and key to hash: a new request or the word just evicted
    always_comb
    begin
        cur_word_next = cur_word_reg;
        key_next      = key_reg;
        if (cmd.load)
        begin
            cur_word_next = (WW'(new_value) << KEY_WIDTH)
                          | WW'(KEY_WIDTH'(lookup_key));
            key_next      = KPW'(KEY_WIDTH'(lookup_key));
        end
        else if (cmd.kick)
        begin
            cur_word_next = rd_data[kick_w];
            key_next      = KPW'(rd_data[kick_w][KEY_WIDTH-1:0]);
        end
        chunk_next = key_next >> INDEX_WIDTH;
    end

    assign chunk = (cnt_reg == CNT_W'(NF)) ? key_reg[LAST +: INDEX_WIDTH]
                                           : chunk_reg[INDEX_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= opcode;
        cur_word_reg <= cur_word_next;
        if (cmd.load || cmd.kick)
        begin
            key_reg   <= key_next;
            chunk_reg <= chunk_next;
            cnt_reg   <= CNT_W'(1);
            for (int w = 0; w < sch_pkg::WAYS; w++)
                idx_reg[w] <= key_next[INDEX_WIDTH-1:0];
        end
        else if (cmd.hash_step)
        begin
            chunk_reg <= chunk_reg >> INDEX_WIDTH;
            cnt_reg   <= cnt_reg + CNT_W'(1);
            for (int w = 0; w < sch_pkg::WAYS; w++)
                idx_reg[w] <= fold(w, idx_reg[w], chunk);
        end
        if (cmd.load)
            t_reg <= '0;
        else if (cmd.kick)
            t_reg <= t_reg + sch_pkg::KICK_W'(1);
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_code;
            if (op_reg == sch_pkg::OPCODE_SET)
                value_reg <= '0;
            else if (cmd.res_code == sch_pkg::STATUS_OK)
                value_reg <= sch_pkg::VALUE_PORT_W'(match_word >> KEY_WIDTH);
            else
                value_reg <= '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxd_reg <= sch_pkg::MAXD_RESET;
            clr_reg  <= '0;
        end
        else
        begin
            if (cfg_write_en)
                maxd_reg <= cfg_write_data;
            if (cmd.clr_step)
                clr_reg <= clr_reg + INDEX_WIDTH'(1);
        end
    end

    generate
        for (genvar g = 0; g < sch_pkg::WAYS; g++)
        begin : g_way
            logic [WW-1:0]          mem [DEPTH];
            logic [INDEX_WIDTH-1:0] addr;
            assign addr = cmd.clr_step ? clr_reg : idx_reg[g];
            always_ff @(posedge clk)
            begin
                if (we[g])
                    mem[addr] <= cmd.clr_step ? '0 : cur_word_reg;
                if (cmd.rd_en)
                    rd_data[g] <= mem[addr];
            end
        end
    endgenerate

    assign stat.op_set    = (op_reg == sch_pkg::OPCODE_SET);
    assign stat.found     = |fnd;
    assign stat.any_empty = |emp;
    assign stat.t_over    = (t_reg > sch_pkg::KICK_W'(maxd_reg));
    assign stat.hash_last = (cnt_reg == CNT_W'(NF));
    assign stat.clr_last  = &clr_reg;

    assign status     = status_reg;
    assign read_value = value_reg;

endmodule

FILE: rtl/sch_ctrl.sv
// ----------------------------------------------------------------------------
// sch_ctrl
// sequencer: clearing pass, hash, probe, update and displacement rounds
// ----------------------------------------------------------------------------
module sch_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output sch_pkg::cmd_t  cmd,
    input  sch_pkg::stat_t stat
);

    sch_pkg::state_t state_reg, state_next;
    logic            first_reg, first_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_busy;

    assign slot_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sch_pkg::S_CLEAR;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        first_next   = first_reg;
        cmd          = '0;
        cmd.res_code = sch_pkg::STATUS_OK;
        in_stall     = 1'b1;
        case (state_reg)
            sch_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = sch_pkg::S_IDLE;
            end
            sch_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                    state_next = sch_pkg::S_HASH;
                end
            end
            sch_pkg::S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                    state_next = sch_pkg::S_READ;
            end
            sch_pkg::S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = sch_pkg::S_EVAL;
            end
            sch_pkg::S_EVAL:
            begin
                if (first_reg && !stat.op_set)
                begin
                    if (!slot_busy)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = stat.found ? sch_pkg::STATUS_OK
                                                  : sch_pkg::STATUS_MISS;
                        state_next   = sch_pkg::S_IDLE;
                    end
                end
                else if (first_reg && stat.found)
                begin
                    if (!slot_busy)
                    begin
                        cmd.wr_match = 1'b1;
                        cmd.res_load = 1'b1;
                        state_next   = sch_pkg::S_IDLE;
                    end
                end
                else if (stat.any_empty)
                begin
                    if (!slot_busy)
                    begin
                        cmd.wr_empty = 1'b1;
                        cmd.res_load = 1'b1;
                        state_next   = sch_pkg::S_IDLE;
                    end
                end
                else if (stat.t_over)
                begin
                    if (!slot_busy)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = sch_pkg::STATUS_FAIL;
                        state_next   = sch_pkg::S_IDLE;
                    end
                end
                else
                begin
                    // displace into the rotating way and rehash the evicted word
                    cmd.kick   = 1'b1;
                    first_next = 1'b0;
                    state_next = sch_pkg::S_HASH;
                end
            end
            default:
            begin
                state_next = sch_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.res_load || slot_busy;
    assign out_valid      = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !slot_busy)
        else $error("result loaded over a pending response");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_match, cmd.wr_empty, cmd.kick, cmd.clr_step}))
        else $error("more than one memory write source");

    a_kick_rehash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kick |=> state_reg == sch_pkg::S_HASH)
        else $error("displacement not followed by rehash");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sch_pkg::S_CLEAR |-> in_stall && !out_valid_reg)
        else $error("activity during clearing pass");

endmodule
